// File: rtl/sctc_pkg.sv
// Shared types and constants for the sector cache tag controller.
// No dependencies; used by sctc_tag_ram and sector_cache_tag_controller.
package sctc_pkg;

	localparam int ENTRIES = 2048;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int SLOT_W  = 11;
	localparam int KEY_W   = 32;
	localparam int STAMP_W = 32;

	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_FLUSH = 2'd2,
		MODE_INVAL = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_VREAD,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic [KEY_W-1:0]   file;
		logic [KEY_W-1:0]   sector;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} ram_wr_t;

endpackage

// File: rtl/sctc_tag_ram.sv
// Tag store: one entry per slot, one write port and one registered read port.
// Depends on sctc_pkg.
module sctc_tag_ram (
	input  logic                        clk,
	input  sctc_pkg::ram_wr_t           wr,
	input  logic                        rd_en,
	input  logic [sctc_pkg::IDX_W-1:0]  rd_addr,
	output sctc_pkg::entry_t            rd_data
);

	sctc_pkg::entry_t mem_q [sctc_pkg::ENTRIES];
	sctc_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/sector_cache_tag_controller.sv
// Sector cache tag controller: fully associative LRU write-back tag store.
// A lookup hit or flush match ends the scan early. A new transaction is accepted only in
// idle, after the previous result has been loaded into the output register.
// The serial scan over the single read port of the tag RAM sets the rate.
// After arst_n the tag RAM is cleared, one slot per cycle, with in_ready low.
// Depends on sctc_pkg and sctc_tag_ram.
module sector_cache_tag_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [sctc_pkg::KEY_W-1:0]   file_key,
	input  logic [sctc_pkg::KEY_W-1:0]   sector_index,
	input  logic                         any_file,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [sctc_pkg::SLOT_W-1:0]  slot,
	output logic                         evicted_dirty,
	output logic [sctc_pkg::KEY_W-1:0]   entry_file,
	output logic [sctc_pkg::KEY_W-1:0]   entry_sector
);

	sctc_pkg::state_t state_q, state_d;
	logic [sctc_pkg::CNT_W-1:0] cnt_q;
	logic vld_s1;
	logic [sctc_pkg::IDX_W-1:0] idx_s1;
	logic [sctc_pkg::STAMP_W-1:0] stamp_q;
	logic out_valid_q;

	sctc_pkg::mode_t mode_q;
	logic [sctc_pkg::KEY_W-1:0] key_q, sec_q;
	logic any_q;

	logic inv_found_q, cln_found_q, drt_found_q;
	logic [sctc_pkg::IDX_W-1:0] inv_idx_q, cln_idx_q, drt_idx_q, vic_idx_q;
	logic [sctc_pkg::STAMP_W-1:0] cln_stamp_q, drt_stamp_q;

	logic res_hit_q, res_evd_q;
	logic [sctc_pkg::IDX_W-1:0] res_slot_q;
	logic [sctc_pkg::KEY_W-1:0] res_file_q, res_sec_q;

	logic hit_q, evd_q;
	logic [sctc_pkg::SLOT_W-1:0] slot_q;
	logic [sctc_pkg::KEY_W-1:0] file_q, sector_q;

	sctc_pkg::ram_wr_t wr;
	logic rd_en;
	logic [sctc_pkg::IDX_W-1:0] rd_addr, vic_idx;
	sctc_pkg::entry_t rd_word_s1, new_word;

	logic is_lookup, is_write, is_flush, is_inval;
	logic key_match, flush_match, inval_match, stop;
	logic [sctc_pkg::STAMP_W-1:0] stamp_nxt;
	logic accept, load_out;

	sctc_tag_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word_s1)
	);

	assign is_write  = (mode_q == sctc_pkg::MODE_WRITE);
	assign is_lookup = (mode_q == sctc_pkg::MODE_READ) || is_write;
	assign is_flush  = (mode_q == sctc_pkg::MODE_FLUSH);
	assign is_inval  = (mode_q == sctc_pkg::MODE_INVAL);

	assign key_match   = rd_word_s1.valid && (rd_word_s1.file == key_q)
		&& (rd_word_s1.sector == sec_q);
	assign flush_match = rd_word_s1.valid && rd_word_s1.dirty
		&& (any_q || (rd_word_s1.file == key_q));
	assign inval_match = rd_word_s1.valid && (rd_word_s1.file == key_q);

	assign stamp_nxt = stamp_q + 1'b1;
	assign in_ready  = (state_q == sctc_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign stop      = (state_q == sctc_pkg::ST_SCAN) && vld_s1
		&& ((is_lookup && key_match) || (is_flush && flush_match));

	// victim: first invalid, else oldest clean, else oldest dirty
	assign vic_idx = inv_found_q ? inv_idx_q : (cln_found_q ? cln_idx_q : drt_idx_q);

	always_comb begin
		new_word = rd_word_s1;
		new_word.valid  = 1'b1;
		new_word.file   = key_q;
		new_word.sector = sec_q;
		new_word.stamp  = stamp_nxt;
		new_word.dirty  = is_write;
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = cnt_q[sctc_pkg::IDX_W-1:0];
		wr.we    = 1'b0;
		wr.addr  = idx_s1;
		wr.data  = rd_word_s1;
		load_out = 1'b0;
		case (state_q)
			sctc_pkg::ST_CLEAR: begin
				wr.we   = 1'b1;
				wr.addr = cnt_q[sctc_pkg::IDX_W-1:0];
				wr.data = '0;
				if (cnt_q == sctc_pkg::CNT_LAST) begin
					state_d = sctc_pkg::ST_IDLE;
				end
			end
			sctc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sctc_pkg::ST_SCAN;
				end
			end
			sctc_pkg::ST_SCAN: begin
				if (stop) begin
					wr.we = 1'b1;
					if (is_lookup) begin
						wr.data = new_word;
						wr.data.dirty = rd_word_s1.dirty | is_write;
					end else begin
						wr.data.dirty = 1'b0;
					end
					state_d = sctc_pkg::ST_DONE;
				end else begin
					if (vld_s1 && is_inval && inval_match) begin
						wr.we = 1'b1;
						wr.data.valid = 1'b0;
						wr.data.dirty = 1'b0;
					end
					if (cnt_q != sctc_pkg::CNT_END) begin
						rd_en = 1'b1;
					end else if (!vld_s1) begin
						state_d = is_lookup ? sctc_pkg::ST_VREAD : sctc_pkg::ST_DONE;
					end
				end
			end
			sctc_pkg::ST_VREAD: begin
				rd_en   = 1'b1;
				rd_addr = vic_idx;
				state_d = sctc_pkg::ST_FILL;
			end
			sctc_pkg::ST_FILL: begin
				wr.we   = 1'b1;
				wr.addr = vic_idx_q;
				wr.data = new_word;
				state_d = sctc_pkg::ST_DONE;
			end
			sctc_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = sctc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sctc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sctc_pkg::ST_CLEAR;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			stamp_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == sctc_pkg::ST_SCAN) && rd_en;
			if (state_q == sctc_pkg::ST_CLEAR || ((state_q == sctc_pkg::ST_SCAN) && rd_en)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == sctc_pkg::ST_IDLE) begin
				cnt_q <= '0;
			end
			if ((stop && is_lookup) || (state_q == sctc_pkg::ST_FILL)) begin
				stamp_q <= stamp_nxt;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[sctc_pkg::IDX_W-1:0];
		if (accept) begin
			mode_q      <= sctc_pkg::mode_t'(mode);
			key_q       <= file_key;
			sec_q       <= sector_index;
			any_q       <= any_file;
			inv_found_q <= 1'b0;
			cln_found_q <= 1'b0;
			drt_found_q <= 1'b0;
			res_hit_q   <= 1'b0;
			res_evd_q   <= 1'b0;
			res_slot_q  <= '0;
			res_file_q  <= '0;
			res_sec_q   <= '0;
		end
		if (stop) begin
			res_hit_q  <= 1'b1;
			res_slot_q <= idx_s1;
			if (is_flush) begin
				res_file_q <= rd_word_s1.file;
				res_sec_q  <= rd_word_s1.sector;
			end
		end else if ((state_q == sctc_pkg::ST_SCAN) && vld_s1 && is_lookup) begin
			if (!rd_word_s1.valid) begin
				if (!inv_found_q) begin
					inv_found_q <= 1'b1;
					inv_idx_q   <= idx_s1;
				end
			end else if (rd_word_s1.dirty) begin
				if (!drt_found_q || (rd_word_s1.stamp < drt_stamp_q)) begin
					drt_found_q <= 1'b1;
					drt_idx_q   <= idx_s1;
					drt_stamp_q <= rd_word_s1.stamp;
				end
			end else begin
				if (!cln_found_q || (rd_word_s1.stamp < cln_stamp_q)) begin
					cln_found_q <= 1'b1;
					cln_idx_q   <= idx_s1;
					cln_stamp_q <= rd_word_s1.stamp;
				end
			end
		end
		if (state_q == sctc_pkg::ST_VREAD) begin
			vic_idx_q <= vic_idx;
		end
		if (state_q == sctc_pkg::ST_FILL) begin
			res_slot_q <= vic_idx_q;
			if (rd_word_s1.valid) begin
				res_evd_q  <= rd_word_s1.dirty;
				res_file_q <= rd_word_s1.file;
				res_sec_q  <= rd_word_s1.sector;
			end
		end
		if (load_out) begin
			hit_q    <= res_hit_q;
			slot_q   <= (sctc_pkg::SLOT_W)'(res_slot_q);
			evd_q    <= res_evd_q;
			file_q   <= res_file_q;
			sector_q <= res_sec_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign evicted_dirty = evd_q;
	assign entry_file    = file_q;
	assign entry_sector  = sector_q;

`ifndef NO_ASSERTIONS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input accepted while a transaction is in progress");

	a_victim_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sctc_pkg::ST_VREAD) |-> (inv_found_q || cln_found_q || drt_found_q))
		else $error("miss fill without a victim candidate");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sctc_pkg::ST_IDLE || state_q == sctc_pkg::ST_DONE) |-> !wr.we)
		else $error("tag store written outside a scan or fill");

	a_stage_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == sctc_pkg::ST_SCAN))
		else $error("scan stage valid outside a scan");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for sector_cache_tag_controller: a tag-store predictor,
// a queued driver and a result monitor, with random idling on both channels.
// Depends on sctc_pkg and the sector_cache_tag_controller RTL.
`timescale 1ns / 1ps

module testbench;
	import sctc_pkg::*;

	localparam int HOLD_AT     = 40;
	localparam int HOLD_LEN    = 6000;
	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_WAIT  = 2100;
	localparam int RANDOM_REQS = 268;

	typedef struct packed {
		mode_t            mode;
		logic [KEY_W-1:0] file_key;
		logic [KEY_W-1:0] sector_index;
		logic             any_file;
	} request_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted_dirty;
		logic [KEY_W-1:0]  entry_file;
		logic [KEY_W-1:0]  entry_sector;
	} cache_result_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [1:0]          mode         = MODE_READ;
	logic [KEY_W-1:0]    file_key     = '0;
	logic [KEY_W-1:0]    sector_index = '0;
	logic                any_file     = 1'b0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic                hit;
	logic [SLOT_W-1:0]   slot;
	logic                evicted_dirty;
	logic [KEY_W-1:0]    entry_file;
	logic [KEY_W-1:0]    entry_sector;

	request_t      request_q[$];
	cache_result_t result_q[$];
	request_t      cur_req;
	int            send_gap   = 0;
	bit            send_calm  = 1'b0;
	int            n_sent     = 0;
	int            recv_stall = 0;
	bit            recv_calm  = 1'b0;
	int            n_results  = 0;
	int            n_errors   = 0;
	int            idle_count = 0;

	bit               tag_valid  [ENTRIES];
	bit               tag_dirty  [ENTRIES];
	bit [KEY_W-1:0]   tag_file   [ENTRIES];
	bit [KEY_W-1:0]   tag_sector [ENTRIES];
	bit [STAMP_W-1:0] tag_stamp  [ENTRIES];
	bit [STAMP_W-1:0] stamp_now = '0;

	sector_cache_tag_controller u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.file_key     (file_key),
		.sector_index (sector_index),
		.any_file     (any_file),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.slot         (slot),
		.evicted_dirty(evicted_dirty),
		.entry_file   (entry_file),
		.entry_sector (entry_sector)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// lowest invalid slot, else oldest clean, else oldest dirty
	function automatic int choose_victim();
		bit               have_clean = 1'b0;
		bit               have_dirty = 1'b0;
		int               clean_idx  = 0;
		int               dirty_idx  = 0;
		bit [STAMP_W-1:0] clean_age  = '0;
		bit [STAMP_W-1:0] dirty_age  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!tag_valid[i])
				return i;
			if (tag_dirty[i]) begin
				if (!have_dirty || tag_stamp[i] < dirty_age) begin
					have_dirty = 1'b1;
					dirty_age  = tag_stamp[i];
					dirty_idx  = i;
				end
			end else if (!have_clean || tag_stamp[i] < clean_age) begin
				have_clean = 1'b1;
				clean_age  = tag_stamp[i];
				clean_idx  = i;
			end
		end
		return have_clean ? clean_idx : dirty_idx;
	endfunction

	function automatic cache_result_t apply_request(request_t r);
		cache_result_t res;
		bit            found;
		int            idx;
		res   = '0;
		found = 1'b0;
		idx   = 0;
		case (r.mode)
			MODE_READ, MODE_WRITE: begin
				for (int i = 0; i < ENTRIES && !found; i++)
					if (tag_valid[i] && tag_file[i] == r.file_key &&
							tag_sector[i] == r.sector_index) begin
						found = 1'b1;
						idx   = i;
					end
				if (found) begin
					res.hit = 1'b1;
				end else begin
					idx = choose_victim();
					if (tag_valid[idx]) begin
						res.evicted_dirty = tag_dirty[idx];
						res.entry_file    = tag_file[idx];
						res.entry_sector  = tag_sector[idx];
					end
					tag_file[idx]   = r.file_key;
					tag_sector[idx] = r.sector_index;
					tag_valid[idx]  = 1'b1;
					tag_dirty[idx]  = 1'b0;
				end
				stamp_now      = stamp_now + 1'b1;
				tag_stamp[idx] = stamp_now;
				if (r.mode == MODE_WRITE)
					tag_dirty[idx] = 1'b1;
				res.slot = SLOT_W'(idx);
			end
			MODE_FLUSH: begin
				for (int i = 0; i < ENTRIES && !found; i++)
					if (tag_valid[i] && tag_dirty[i] && (r.any_file || tag_file[i] == r.file_key)) begin
						found            = 1'b1;
						res.hit          = 1'b1;
						res.slot         = SLOT_W'(i);
						res.entry_file   = tag_file[i];
						res.entry_sector = tag_sector[i];
						tag_dirty[i]     = 1'b0;
					end
			end
			MODE_INVAL: begin
				for (int i = 0; i < ENTRIES; i++)
					if (tag_valid[i] && tag_file[i] == r.file_key) begin
						tag_valid[i] = 1'b0;
						tag_dirty[i] = 1'b0;
					end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic add_request(mode_t m, logic [KEY_W-1:0] f, logic [KEY_W-1:0] s, logic a);
		request_t r;
		r.mode         = m;
		r.file_key     = f;
		r.sector_index = s;
		r.any_file     = a;
		request_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				result_q.push_back(apply_request(cur_req));
				n_sent++;
				if ($urandom_range(0, 7) == 0)
					send_calm = !send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, 3);
			end
			if (in_valid && !in_ready) begin
				// hold the transaction until accepted
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (request_q.size() > 0) begin
				cur_req = request_q.pop_front();
				in_valid     <= 1'b1;
				mode         <= cur_req.mode;
				file_key     <= cur_req.file_key;
				sector_index <= cur_req.sector_index;
				any_file     <= cur_req.any_file;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		cache_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (result_q.size() == 0) begin
					$error("result with no transaction pending: slot %0d", slot);
					n_errors++;
				end else begin
					e = result_q.pop_front();
					if (hit !== e.hit) begin
						$error("hit: expected %0d, actual %0d", e.hit, hit);
						n_errors++;
					end
					if (slot !== e.slot) begin
						$error("slot: expected %0d, actual %0d", e.slot, slot);
						n_errors++;
					end
					if (evicted_dirty !== e.evicted_dirty) begin
						$error("evicted_dirty: expected %0d, actual %0d",
							e.evicted_dirty, evicted_dirty);
						n_errors++;
					end
					if (entry_file !== e.entry_file) begin
						$error("entry_file: expected %h, actual %h", e.entry_file, entry_file);
						n_errors++;
					end
					if (entry_sector !== e.entry_sector) begin
						$error("entry_sector: expected %h, actual %h",
							e.entry_sector, entry_sector);
						n_errors++;
					end
				end
				if ($urandom_range(0, 7) == 0)
					recv_calm = !recv_calm;
				recv_stall = recv_calm ? 0 : $urandom_range(0, 3);
				// long back-pressure so the block stalls its input
				if (n_results == HOLD_AT)
					recv_stall = HOLD_LEN;
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			out_ready <= (recv_stall == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_count = 0;
			else
				idle_count++;
			if (idle_count >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int    roll;
		int    n_total;
		mode_t m;

		add_request(MODE_READ,  32'd1,        32'd0,        1'b0);
		add_request(MODE_READ,  32'd1,        32'd0,        1'b1);
		add_request(MODE_WRITE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
		add_request(MODE_WRITE, 32'd1,        32'd0,        1'b0);
		add_request(MODE_READ,  32'd0,        32'hFFFFFFFF, 1'b0);
		add_request(MODE_WRITE, 32'd2,        32'd5,        1'b0);
		add_request(MODE_FLUSH, 32'd2,        32'h89ABCDEF, 1'b0);
		add_request(MODE_FLUSH, 32'd2,        32'd0,        1'b0);
		add_request(MODE_FLUSH, 32'd0,        32'd0,        1'b1);
		add_request(MODE_FLUSH, 32'd0,        32'hFFFFFFFF, 1'b1);
		add_request(MODE_FLUSH, 32'd7,        32'd0,        1'b1);
		add_request(MODE_INVAL, 32'd1,        32'd3,        1'b1);
		add_request(MODE_INVAL, 32'd9,        32'd0,        1'b0);
		add_request(MODE_READ,  32'd3,        32'd7,        1'b0);
		add_request(MODE_WRITE, 32'd2,        32'd5,        1'b1);
		add_request(MODE_INVAL, 32'd2,        32'd0,        1'b0);
		add_request(MODE_FLUSH, 32'd2,        32'd0,        1'b0);
		add_request(MODE_WRITE, 32'hFFFFFFFF, 32'd0,        1'b0);
		add_request(MODE_READ,  32'hAAAAAAAA, 32'h55555555, 1'b0);
		add_request(MODE_WRITE, 32'h55555555, 32'hAAAAAAAA, 1'b1);
		add_request(MODE_INVAL, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
		add_request(MODE_FLUSH, 32'hFFFFFFFF, 32'd0,        1'b1);

		// mostly a small working set so hits, flushes and refills interact
		for (int n = 0; n < RANDOM_REQS; n++) begin
			roll = $urandom_range(0, 99);
			m = (roll < 40) ? MODE_READ : (roll < 75) ? MODE_WRITE :
				(roll < 90) ? MODE_FLUSH : MODE_INVAL;
			if ($urandom_range(0, 99) < 85)
				add_request(m, $urandom_range(1, 6), $urandom_range(0, 15),
					1'($urandom_range(0, 1)));
			else
				add_request(m, $urandom, $urandom, 1'($urandom_range(0, 1)));
		end
		n_total = request_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent < n_total)
			@(negedge clk);
		while (result_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/sctc_pkg.sv
rtl/sctc_tag_ram.sv
rtl/sector_cache_tag_controller.sv
test/testbench.sv
